[rtl/msched_pkg.sv]
// shared types and constants of the edf scheduler
`default_nettype none
package msched_pkg;
  localparam int unsigned TASKS = 16;
  localparam int unsigned CPUS  = 4;
  localparam int unsigned TW    = $clog2(TASKS);
  localparam int unsigned CW    = $clog2(CPUS);

  localparam logic [0:0] CFG_ACTIVE_CPUS = 1'b0;
  localparam logic [0:0] CFG_TASK_COUNT  = 1'b1;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  typedef enum logic [1:0] {
    ST_EMPTY = 2'd0,
    ST_READY = 2'd1,
    ST_RUN   = 2'd2,
    ST_DONE  = 2'd3
  } task_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PICK,
    S_ASSIGN,
    S_REPORT
  } sched_state_e;

  typedef struct packed {
    logic        action;
    logic [3:0]  task_slot;
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [15:0] deadline;
  } in_item_t;

  typedef struct packed {
    logic [15:0] tick_cycle;
    logic [1:0]  cpu_index;
    logic        busy_res;
    logic [3:0]  running_task;
    logic        finished;
    logic        missed;
    logic [15:0] completion_cycle;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic          found;
    logic [15:0]   dl;
    logic [TW-1:0] idx;
  } pick_t;
endpackage
`default_nettype wire

[rtl/msched_front.sv]
// input queue between the handshake and the scheduler engine
`default_nettype none
module msched_front (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  msched_pkg::in_item_t  in_item_i,
  output logic                  q_valid_o,
  output msched_pkg::in_item_t  q_item_o,
  input  wire                   q_pop_i
);
  import msched_pkg::*;

  in_item_t   mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = q_pop_i ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, q_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_item_i;
    end
  end
endmodule
`default_nettype wire

[rtl/msched_back.sv]
// scheduler engine: task table, cpu assignment and per-cpu reporting
`default_nettype none
module msched_back (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   cfg_we_i,
  input  wire  [0:0]            cfg_idx_i,
  input  wire  [4:0]            cfg_data_i,
  input  wire                   q_valid_i,
  input  msched_pkg::in_item_t  q_item_i,
  output logic                  q_pop_o,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output msched_pkg::out_item_t out_item_o
);
  import msched_pkg::*;

  task_status_e  status_q [TASKS];
  logic [15:0]   arr_q [TASKS];
  logic [15:0]   dl_q  [TASKS];
  logic [15:0]   rem_q [TASKS];
  logic          busy_q [CPUS];
  logic [TW-1:0] tid_q  [CPUS];
  logic [15:0]   cycle_q;
  logic [2:0]    active_q;
  logic [4:0]    tcount_q;

  sched_state_e  state_q, state_d;
  logic [CW:0]   cpu_q, cpu_d;
  pick_t         best_q;
  pick_t         node [2*TASKS];
  logic          out_valid_q;
  out_item_t     out_q;

  logic [CW:0]   ncpu, ncpu_new;
  logic [4:0]    lim;
  logic [CW-1:0] ci;
  logic          do_load, do_assign, do_preempt, do_report;
  logic          rep_fin;
  logic [16:0]   now1;

  function automatic logic [CW:0] cpus_of(input logic [2:0] v);
    logic [CW:0] r;
    r = (v == 3'd0) ? (CW+1)'(1) : ({1'b0, v} > CPUS) ? (CW+1)'(CPUS) : v[CW:0];
    return r;
  endfunction

  assign ncpu     = cpus_of(active_q);
  assign ncpu_new = cpus_of(cfg_data_i[2:0]);
  assign lim      = (tcount_q > 5'(TASKS)) ? 5'(TASKS) : tcount_q;
  assign ci       = cpu_q[CW-1:0];
  assign now1     = {1'b0, cycle_q} + 17'd1;

  // earliest-deadline tree, left child wins ties
  always_comb begin
    node[0] = '0;
    for (int i = 0; i < TASKS; i++) begin
      node[TASKS+i].found = (5'(i) < lim) && (status_q[i] == ST_READY)
                            && (arr_q[i] <= cycle_q);
      node[TASKS+i].dl    = dl_q[i];
      node[TASKS+i].idx   = TW'(i);
    end
    for (int n = TASKS-1; n >= 1; n--) begin
      if (node[2*n].found && (!node[2*n+1].found || node[2*n].dl <= node[2*n+1].dl)) begin
        node[n] = node[2*n];
      end else begin
        node[n] = node[2*n+1];
      end
    end
  end

  assign do_load    = (state_q == S_IDLE) && q_valid_i && (q_item_i.action == ACT_LOAD);
  assign do_assign  = (state_q == S_ASSIGN) && (cpu_q < ncpu) && best_q.found
                      && !busy_q[ci];
  assign do_preempt = (state_q == S_ASSIGN) && (cpu_q < ncpu) && best_q.found
                      && busy_q[ci] && (best_q.dl < dl_q[tid_q[ci]]);
  assign do_report  = (state_q == S_REPORT) && (!out_valid_q || out_ready_i);
  assign rep_fin    = busy_q[ci] && (rem_q[tid_q[ci]] <= 16'd1);

  always_comb begin
    state_d = state_q;
    cpu_d   = cpu_q;
    q_pop_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          if (q_item_i.action == ACT_TICK) begin
            state_d = S_PICK;
            cpu_d   = '0;
          end
        end
      end
      S_PICK: state_d = S_ASSIGN;
      S_ASSIGN: begin
        if (cpu_q >= ncpu || !best_q.found) begin
          state_d = S_REPORT;
          cpu_d   = '0;
        end else begin
          cpu_d = cpu_q + 1'b1;
          if (do_assign || do_preempt) state_d = S_PICK;
        end
      end
      S_REPORT: begin
        if (do_report) begin
          cpu_d = cpu_q + 1'b1;
          if (cpu_q + 1'b1 == ncpu) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cpu_q       <= '0;
      out_valid_q <= 1'b0;
      cycle_q     <= '0;
      active_q    <= 3'd4;
      tcount_q    <= '0;
      for (int i = 0; i < TASKS; i++) status_q[i] <= ST_EMPTY;
      for (int c = 0; c < CPUS; c++) busy_q[c] <= 1'b0;
    end else begin
      state_q <= state_d;
      cpu_q   <= cpu_d;
      if (out_ready_i) out_valid_q <= 1'b0;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_ACTIVE_CPUS) begin
          active_q <= cfg_data_i[2:0];
          // cpus leaving use hand their tasks back
          for (int c = 0; c < CPUS; c++) begin
            if ((CW+1)'(c) >= ncpu_new && busy_q[c]) begin
              busy_q[c]           <= 1'b0;
              status_q[tid_q[c]]  <= ST_READY;
            end
          end
        end else begin
          tcount_q <= cfg_data_i;
        end
      end
      if (do_load) begin
        for (int c = 0; c < CPUS; c++) begin
          if (busy_q[c] && tid_q[c] == q_item_i.task_slot[TW-1:0]) busy_q[c] <= 1'b0;
        end
        status_q[q_item_i.task_slot[TW-1:0]] <= ST_READY;
      end
      if (do_assign || do_preempt) begin
        if (do_preempt) status_q[tid_q[ci]] <= ST_READY;
        busy_q[ci]             <= 1'b1;
        status_q[best_q.idx]   <= ST_RUN;
      end
      if (do_report) begin
        out_valid_q <= 1'b1;
        if (rep_fin) begin
          busy_q[ci]          <= 1'b0;
          status_q[tid_q[ci]] <= ST_DONE;
        end
        if (cpu_q + 1'b1 == ncpu && cycle_q != 16'hFFFF) cycle_q <= cycle_q + 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_PICK) best_q <= node[1];
    if (do_load) begin
      arr_q[q_item_i.task_slot[TW-1:0]] <= q_item_i.arrival;
      rem_q[q_item_i.task_slot[TW-1:0]] <= q_item_i.burst;
      dl_q[q_item_i.task_slot[TW-1:0]]  <= q_item_i.deadline;
    end
    if (do_assign || do_preempt) tid_q[ci] <= best_q.idx;
    if (do_report) begin
      if (busy_q[ci]) begin
        rem_q[tid_q[ci]] <= rep_fin ? 16'd0 : rem_q[tid_q[ci]] - 16'd1;
      end
      out_q.tick_cycle       <= cycle_q;
      out_q.cpu_index        <= 2'(ci);
      out_q.busy_res         <= busy_q[ci];
      out_q.running_task     <= busy_q[ci] ? 4'(tid_q[ci]) : 4'd0;
      out_q.finished         <= rep_fin;
      out_q.missed           <= rep_fin && (now1 > {1'b0, dl_q[tid_q[ci]]});
      out_q.completion_cycle <= rep_fin ? ((cycle_q == 16'hFFFF) ? 16'hFFFF : now1[15:0])
                                        : 16'd0;
      out_q.last             <= (cpu_q + 1'b1 == ncpu);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
endmodule
`default_nettype wire

[rtl/multi_cpu_edf_scheduler_core.sv]
// global preemptive edf scheduler: input queue plus scheduling engine
// load item: popped from the queue and written into the task table while the engine is idle
// tick item: a pop, a pick step, one assign step per cpu visited, one more pick per
// assignment made and a closing assign step, then one report per cpu as the output takes it
// results are registered in their report step; the tree search is registered in the pick step
// reset: task table empty, all cpus idle, tick counter zero, 4 cpus, 0 tasks
`default_nettype none
module multi_cpu_edf_scheduler_core (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   cfg_we_i,
  input  wire  [0:0]            cfg_idx_i,
  input  wire  [4:0]            cfg_data_i,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  msched_pkg::in_item_t  in_item_i,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output msched_pkg::out_item_t out_item_o
);
  import msched_pkg::*;

  logic     q_valid, q_pop;
  in_item_t q_item;

  msched_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  msched_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );
endmodule
`default_nettype wire

[tb/multi_cpu_edf_scheduler_core_tb.sv]
// testbench for the edf scheduler core: predicts each tick's per-cpu rows and checks them
`timescale 1ns / 1ps
module multi_cpu_edf_scheduler_core_tb;
  import msched_pkg::*;

  localparam int unsigned NO_TASK   = TASKS;
  localparam int unsigned SETTLE    = 40;
  localparam int unsigned WD_LIMIT  = 5000;
  localparam int unsigned RAND_ITEMS = 450;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      cfg_we_i = 1'b0;
  logic      cfg_idx_i = 1'b0;
  logic [4:0] cfg_data_i = '0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;

  multi_cpu_edf_scheduler_core DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .in_item_i,
    .out_valid_o, .out_ready_i, .out_item_o
  );

  always #6 clk_i = ~clk_i;

  // scheduler shadow state
  task_status_e sh_status [TASKS];
  logic [15:0]  sh_arrival [TASKS];
  logic [15:0]  sh_deadline [TASKS];
  logic [15:0]  sh_remaining [TASKS];
  int unsigned  sh_cpu [CPUS];
  logic [15:0]  sh_tick;
  int unsigned  sh_active;
  int unsigned  sh_tcount;

  out_item_t cpu_rows_q[$];
  int        n_errors = 0;
  bit        idle_en = 1'b0;
  int        rx_hold = 0;
  int        quiet_cycles = 0;

  function automatic int unsigned cpus_used();
    if (sh_active == 0) return 1;
    if (sh_active > CPUS) return CPUS;
    return sh_active;
  endfunction

  function automatic int unsigned edf_pick();
    int unsigned lim, best, best_dl;
    lim = (sh_tcount > TASKS) ? TASKS : sh_tcount;
    best = NO_TASK;
    best_dl = 100000;
    for (int unsigned i = 0; i < lim; i++) begin
      if (sh_status[i] == ST_READY && sh_arrival[i] <= sh_tick && sh_deadline[i] < best_dl) begin
        best_dl = sh_deadline[i];
        best = i;
      end
    end
    return best;
  endfunction

  function automatic void shadow_reset();
    for (int i = 0; i < TASKS; i++) begin
      sh_status[i] = ST_EMPTY;
      sh_arrival[i] = '0;
      sh_deadline[i] = '0;
      sh_remaining[i] = '0;
    end
    for (int i = 0; i < CPUS; i++) sh_cpu[i] = NO_TASK;
    sh_tick = '0;
    sh_active = 4;
    sh_tcount = 0;
  endfunction

  function automatic void shadow_config(logic idx, logic [4:0] val);
    if (idx == CFG_ACTIVE_CPUS) begin
      sh_active = val & 5'd7;
      for (int unsigned i = cpus_used(); i < CPUS; i++) begin
        if (sh_cpu[i] < TASKS) begin
          sh_status[sh_cpu[i]] = ST_READY;
          sh_cpu[i] = NO_TASK;
        end
      end
    end else begin
      sh_tcount = val;
    end
  endfunction

  function automatic void schedule_item(in_item_t it);
    int unsigned ncpu, best, cur, t;
    int unsigned now;
    out_item_t row;
    ncpu = cpus_used();
    now = sh_tick;
    if (it.action == ACT_LOAD) begin
      for (int i = 0; i < CPUS; i++) if (sh_cpu[i] == it.task_slot) sh_cpu[i] = NO_TASK;
      sh_arrival[it.task_slot] = it.arrival;
      sh_remaining[it.task_slot] = it.burst;
      sh_deadline[it.task_slot] = it.deadline;
      sh_status[it.task_slot] = ST_READY;
      return;
    end
    best = edf_pick();
    for (int unsigned i = 0; i < ncpu && best < TASKS; i++) begin
      cur = sh_cpu[i];
      if (cur >= TASKS) begin
        sh_cpu[i] = best;
        sh_status[best] = ST_RUN;
        best = edf_pick();
      end else if (sh_deadline[best] < sh_deadline[cur]) begin
        sh_status[cur] = ST_READY;
        sh_cpu[i] = best;
        sh_status[best] = ST_RUN;
        best = edf_pick();
      end
    end
    for (int unsigned i = 0; i < ncpu; i++) begin
      t = sh_cpu[i];
      row = '0;
      row.tick_cycle = now[15:0];
      row.cpu_index = i[1:0];
      if (t < TASKS) begin
        row.busy_res = 1'b1;
        row.running_task = t[3:0];
        if (sh_remaining[t] <= 1) begin
          sh_remaining[t] = '0;
          sh_status[t] = ST_DONE;
          sh_cpu[i] = NO_TASK;
          row.finished = 1'b1;
          row.missed = (now + 1 > sh_deadline[t]);
          row.completion_cycle = (now + 1 > 16'hFFFF) ? 16'hFFFF : 16'(now + 1);
        end else begin
          sh_remaining[t] = sh_remaining[t] - 16'd1;
        end
      end
      row.last = (i + 1 == ncpu);
      cpu_rows_q.push_back(row);
    end
    if (sh_tick != 16'hFFFF) sh_tick = sh_tick + 16'd1;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (cpu_rows_q.size() == 0) begin
        $display("%0t unexpected item: expected none, actual %p", $time, out_item_o);
        n_errors++;
      end else begin
        if (out_item_o !== cpu_rows_q[0]) begin
          $display("%0t mismatch: expected %p, actual %p", $time, cpu_rows_q[0], out_item_o);
          n_errors++;
        end
        void'(cpu_rows_q.pop_front());
      end
    end
  end

  // receiver with random stalls and an optional long hold-off
  always @(posedge clk_i) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= idle_en ? ($urandom_range(0, 99) >= 25) : 1'b1;
    end
  end

  // watchdog on cycles with no item moving
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WD_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic send_item(in_item_t it);
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    schedule_item(it);
    if (idle_en && $urandom_range(0, 99) < 25) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic stop_sending();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_results();
    while (cpu_rows_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic [4:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    shadow_config(idx, val);
    cfg_we_i <= 1'b0;
  endtask

  function automatic in_item_t load_item(logic [3:0] slot, logic [15:0] arr,
                                         logic [15:0] bur, logic [15:0] dl);
    in_item_t it;
    it.action = ACT_LOAD;
    it.task_slot = slot;
    it.arrival = arr;
    it.burst = bur;
    it.deadline = dl;
    return it;
  endfunction

  function automatic in_item_t noise_item();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return in_item_t'(r[$bits(in_item_t)-1:0]);
  endfunction

  function automatic in_item_t tick_item();
    in_item_t it;
    it = noise_item();
    it.action = ACT_TICK;
    return it;
  endfunction

  // mostly plausible task sets around the current tick, some raw noise
  function automatic in_item_t random_item();
    in_item_t it;
    if ($urandom_range(0, 99) < 15) begin
      it = noise_item();
    end else if ($urandom_range(0, 99) < 40) begin
      it = load_item(4'($urandom_range(0, 15)), sh_tick + 16'($urandom_range(0, 4)),
                     16'($urandom_range(1, 6)), sh_tick + 16'($urandom_range(0, 30)));
    end else begin
      it = tick_item();
    end
    return it;
  endfunction

  task automatic test_directed();
    write_cfg(CFG_TASK_COUNT, 5'd16);
    write_cfg(CFG_ACTIVE_CPUS, 5'd4);
    send_item(load_item(4'd0, 16'd0, 16'd3, 16'd10));
    send_item(load_item(4'd1, 16'd0, 16'd0, 16'd0));       // zero burst
    send_item(load_item(4'd2, 16'd0, 16'd4, 16'd10));      // tie with entry 0
    send_item(load_item(4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_item(load_item(4'd3, 16'd1, 16'd5, 16'd20));
    send_item(load_item(4'd4, 16'd0, 16'd6, 16'd30));
    send_item(load_item(4'd5, 16'd0, 16'd2, 16'd40));
    send_item(tick_item());
    send_item(tick_item());
    send_item(load_item(4'd6, 16'd0, 16'd2, 16'd1));       // preempts
    send_item(tick_item());
    send_item(load_item(4'd0, 16'd0, 16'd2, 16'd50));      // reload after it finished
    send_item(tick_item());
    send_item(tick_item());
    stop_sending();
    wait_results();
    write_cfg(CFG_ACTIVE_CPUS, 5'd1);                      // shrink while busy
    write_cfg(CFG_TASK_COUNT, 5'd4);                       // running tasks outside count
    send_item(tick_item());
    send_item(tick_item());
    stop_sending();
    wait_results();
    write_cfg(CFG_ACTIVE_CPUS, 5'd0);
    write_cfg(CFG_TASK_COUNT, 5'd31);
    send_item(tick_item());
    send_item(tick_item());
    stop_sending();
    wait_results();
    write_cfg(CFG_ACTIVE_CPUS, 5'd7);
    send_item(tick_item());
    stop_sending();
    wait_results();
  endtask

  task automatic test_random_configs();
    logic [4:0] acts [6] = '{5'd4, 5'd1, 5'd2, 5'd3, 5'd6, 5'd0};
    logic [4:0] cnts [6] = '{5'd16, 5'd1, 5'd8, 5'd0, 5'd20, 5'd12};
    for (int p = 0; p < 6; p++) begin
      write_cfg(CFG_ACTIVE_CPUS, acts[p]);
      write_cfg(CFG_TASK_COUNT, cnts[p]);
      idle_en = (p != 2);   // one long stretch with no idling
      repeat (RAND_ITEMS / 6) send_item(random_item());
      stop_sending();
      if (p == 3) begin
        wait_results();     // sender pause until everything drained
      end
      wait_results();
    end
    idle_en = 1'b1;
  endtask

  task automatic test_backpressure();
    write_cfg(CFG_ACTIVE_CPUS, 5'd4);
    write_cfg(CFG_TASK_COUNT, 5'd16);
    rx_hold = 300;
    repeat (40) send_item(random_item());
    stop_sending();
    wait_results();
  endtask

  initial begin
    shadow_reset();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    idle_en = 1'b1;
    test_directed();
    test_random_configs();
    test_backpressure();
    if (n_errors == 0 && cpu_rows_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
